// ===== hw/rtl/zop_pkg.sv =====
// Shared constants, payload types and helpers for the zone overlap priority hit block.
package zop_pkg;

    // Coordinate format and zone set.
    localparam int COORD_FRAC_BITS = 11;
    localparam int COORD_W         = COORD_FRAC_BITS + 1;
    localparam logic [COORD_W-1:0] COORD_ONE = COORD_W'(1 << COORD_FRAC_BITS);
    localparam int NUM_ZONES       = 4;
    localparam int NUM_ZONE_REGS   = 4;
    localparam int ZONE_REG_W      = 5 * COORD_W + 1;
    localparam int CFG_IDX_W       = 2;
    localparam int LEVEL_W         = 2;

    // Zone register packing: slot k sits at bits k*COORD_W.
    localparam int SLOT_Y2     = 0;
    localparam int SLOT_X2     = 1;
    localparam int SLOT_Y1     = 2;
    localparam int SLOT_X1     = 3;
    localparam int SLOT_THR    = 4;
    localparam int ACTIVE_BIT  = 5 * COORD_W;

    // Area and product widths.
    localparam int AREA_W = 2 * COORD_W - 1;
    localparam int PROD_W = COORD_W + AREA_W;

    // Divider: quotient bits retired per stage.
    localparam int DIV_STAGES = 6;
    localparam int DIV_STEPS  = (COORD_W + DIV_STAGES - 1) / DIV_STAGES;

    typedef logic [ZONE_REG_W-1:0] t_zone_reg;

    typedef struct packed {
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_bottom;
    } t_box_in;

    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] zone_level;
        logic [COORD_W-1:0] overlap_ratio;
    } t_hit_out;

    // Clipped extents per zone after the first stage.
    typedef struct packed {
        logic [COORD_W-1:0]                bw;
        logic [COORD_W-1:0]                bh;
        logic [NUM_ZONES-1:0]              active;
        logic [NUM_ZONES-1:0][COORD_W-1:0] thr;
        logic [NUM_ZONES-1:0][COORD_W-1:0] iw;
        logic [NUM_ZONES-1:0][COORD_W-1:0] ih;
    } t_clip;

    // Areas per zone after the multiply stage.
    typedef struct packed {
        logic [AREA_W-1:0]                 area;
        logic [NUM_ZONES-1:0][AREA_W-1:0]  inter;
        logic [NUM_ZONES-1:0][COORD_W-1:0] thr;
        logic [NUM_ZONES-1:0]              active;
    } t_geom;

    // Per-zone hit flags.
    typedef struct packed {
        logic [AREA_W-1:0]                area;
        logic [NUM_ZONES-1:0][AREA_W-1:0] inter;
        logic [NUM_ZONES-1:0]             hit;
    } t_zhit;

    // Winner and the operands of its ratio division.
    typedef struct packed {
        logic               hit;
        logic [LEVEL_W-1:0] level;
        logic               nz;
        logic [AREA_W-1:0]  rem;
        logic [AREA_W-1:0]  area;
        logic [COORD_W-1:0] quo;
    } t_div;

    // Coordinates above one are held at one.
    function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] v);
        return (v > COORD_ONE) ? COORD_ONE : v;
    endfunction

endpackage

// ===== hw/rtl/zop_geom.sv =====
// Box and zone clipping followed by the box and intersection area multiplies.
module zop_geom (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  zop_pkg::t_zone_reg     i_zone [zop_pkg::NUM_ZONES],
    input  logic                   i_valid,
    output logic                   o_ready,
    input  zop_pkg::t_box_in       i_data,
    output logic                   o_valid,
    input  logic                   i_ready,
    output zop_pkg::t_geom         o_data
);

    localparam int CW = zop_pkg::COORD_W;
    localparam int NZ = zop_pkg::NUM_ZONES;

    logic [1:0]      r_vld;
    logic [1:0]      w_en;
    zop_pkg::t_clip  r_clip;
    zop_pkg::t_clip  n_clip;
    zop_pkg::t_geom  r_geom;
    zop_pkg::t_geom  n_geom;

    // Stage advance: a stage loads when empty or when its beat moves on.
    always_comb begin
        w_en[1] = !r_vld[1] || i_ready;
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[1];
    assign o_data  = r_geom;

    // Clip the box against every zone.
    always_comb begin
        logic [CW-1:0] bx1, by1, bx2, by2;
        logic [CW-1:0] zx1, zy1, zx2, zy2;
        logic [CW-1:0] ix1, iy1, ix2, iy2;
        logic [CW:0]   dw, dh, diw, dih;
        logic          area_ok;
        logic          iok;
        n_clip = '0;
        bx1 = zop_pkg::clamp_coord(i_data.box_left);
        by1 = zop_pkg::clamp_coord(i_data.box_top);
        bx2 = zop_pkg::clamp_coord(i_data.box_right);
        by2 = zop_pkg::clamp_coord(i_data.box_bottom);
        dw = {1'b0, bx2} - {1'b0, bx1};
        dh = {1'b0, by2} - {1'b0, by1};
        area_ok = !dw[CW] && (dw != '0) && !dh[CW] && (dh != '0);
        n_clip.bw = area_ok ? dw[CW-1:0] : '0;
        n_clip.bh = area_ok ? dh[CW-1:0] : '0;
        for (int z = 0; z < NZ; z++) begin
            zx1 = zop_pkg::clamp_coord(i_zone[z][zop_pkg::SLOT_X1*CW +: CW]);
            zy1 = zop_pkg::clamp_coord(i_zone[z][zop_pkg::SLOT_Y1*CW +: CW]);
            zx2 = zop_pkg::clamp_coord(i_zone[z][zop_pkg::SLOT_X2*CW +: CW]);
            zy2 = zop_pkg::clamp_coord(i_zone[z][zop_pkg::SLOT_Y2*CW +: CW]);
            ix1 = (bx1 > zx1) ? bx1 : zx1;
            iy1 = (by1 > zy1) ? by1 : zy1;
            ix2 = (bx2 < zx2) ? bx2 : zx2;
            iy2 = (by2 < zy2) ? by2 : zy2;
            diw = {1'b0, ix2} - {1'b0, ix1};
            dih = {1'b0, iy2} - {1'b0, iy1};
            iok = area_ok && !diw[CW] && (diw != '0) && !dih[CW] && (dih != '0);
            n_clip.active[z] = i_zone[z][zop_pkg::ACTIVE_BIT];
            n_clip.thr[z]    = i_zone[z][zop_pkg::SLOT_THR*CW +: CW];
            n_clip.iw[z]     = iok ? diw[CW-1:0] : '0;
            n_clip.ih[z]     = iok ? dih[CW-1:0] : '0;
        end
    end

    // Box area and intersection areas.
    always_comb begin
        logic [2*CW-1:0] p;
        n_geom = '0;
        p = {{CW{1'b0}}, r_clip.bw} * {{CW{1'b0}}, r_clip.bh};
        n_geom.area = p[zop_pkg::AREA_W-1:0];
        for (int z = 0; z < NZ; z++) begin
            p = {{CW{1'b0}}, r_clip.iw[z]} * {{CW{1'b0}}, r_clip.ih[z]};
            n_geom.inter[z]  = p[zop_pkg::AREA_W-1:0];
            n_geom.thr[z]    = r_clip.thr[z];
            n_geom.active[z] = r_clip.active[z];
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_clip <= n_clip;
        end
        if (w_en[1]) begin
            r_geom <= n_geom;
        end
    end

endmodule

// ===== hw/rtl/zop_hit.sv =====
// Per-zone threshold test and lowest-numbered winner selection.
module zop_hit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  zop_pkg::t_geom  i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output zop_pkg::t_div   o_data
);

    localparam int NZ = zop_pkg::NUM_ZONES;
    localparam int PW = zop_pkg::PROD_W;

    logic [1:0]      r_vld;
    logic [1:0]      w_en;
    zop_pkg::t_zhit  r_zhit;
    zop_pkg::t_zhit  n_zhit;
    zop_pkg::t_div   r_sel;
    zop_pkg::t_div   n_sel;

    always_comb begin
        w_en[1] = !r_vld[1] || i_ready;
        w_en[0] = !r_vld[0] || w_en[1];
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[1];
    assign o_data  = r_sel;

    // Exact threshold test: intersection * one >= threshold * area; with no intersection, only a zero threshold hits.
    always_comb begin
        logic [PW-1:0] lhs;
        logic [PW-1:0] rhs;
        n_zhit = '0;
        n_zhit.area  = i_data.area;
        n_zhit.inter = i_data.inter;
        for (int z = 0; z < NZ; z++) begin
            lhs = PW'({i_data.inter[z], {zop_pkg::COORD_FRAC_BITS{1'b0}}});
            rhs = PW'(i_data.thr[z]) * PW'(i_data.area);
            if (i_data.inter[z] != '0) begin
                n_zhit.hit[z] = i_data.active[z] && (lhs >= rhs);
            end else begin
                n_zhit.hit[z] = i_data.active[z] && (i_data.thr[z] == '0);
            end
        end
    end

    // Lowest-numbered hitting zone wins.
    always_comb begin
        n_sel = '0;
        n_sel.area = r_zhit.area;
        for (int z = NZ - 1; z >= 0; z--) begin
            if (r_zhit.hit[z]) begin
                n_sel.hit   = 1'b1;
                n_sel.level = zop_pkg::LEVEL_W'(z);
                n_sel.rem   = r_zhit.inter[z];
            end
        end
        n_sel.nz = (n_sel.rem != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_valid;
            end
            if (w_en[1]) begin
                r_vld[1] <= r_vld[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_zhit <= n_zhit;
        end
        if (w_en[1]) begin
            r_sel <= n_sel;
        end
    end

endmodule

// ===== hw/rtl/zop_div.sv =====
// Pipelined restoring divider for the overlap ratio, with the output register.
module zop_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  zop_pkg::t_div     i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output zop_pkg::t_hit_out o_data
);

    localparam int NS = zop_pkg::DIV_STAGES;
    localparam int NT = zop_pkg::DIV_STEPS;
    localparam int CW = zop_pkg::COORD_W;
    localparam int AW = zop_pkg::AREA_W;

    logic [NS-1:0]  r_vld;
    logic [NS-1:0]  w_en;
    logic [NS-1:0]  w_vsrc;
    zop_pkg::t_div  w_src [NS];
    zop_pkg::t_div  r_st [NS];
    zop_pkg::t_div  n_st [NS];

    // Ready chain from the output back to the input.
    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_ready = w_en[0];
    assign o_valid = r_vld[NS-1];

    // What each stage loads: the input beat or the stage before it.
    assign w_vsrc = {r_vld[NS-2:0], i_valid};

    always_comb begin
        w_src[0] = i_data;
        for (int k = 1; k < NS; k++) begin
            w_src[k] = r_st[k-1];
        end
    end

    // Each stage retires two quotient bits. The first bit compares without
    // a shift, since the intersection never exceeds twice the area.
    always_comb begin
        logic [AW:0] sh;
        logic        ge;
        for (int s = 0; s < NS; s++) begin
            n_st[s] = w_src[s];
            for (int t = 0; t < NT; t++) begin
                if (s * NT + t < CW) begin
                    sh = (s * NT + t == 0) ? {1'b0, n_st[s].rem}
                                           : {n_st[s].rem, 1'b0};
                    ge = (sh >= {1'b0, n_st[s].area});
                    n_st[s].rem = ge ? AW'(sh - {1'b0, n_st[s].area}) : sh[AW-1:0];
                    n_st[s].quo = {n_st[s].quo[CW-2:0], ge};
                end
            end
        end
    end

    // Result beat; the ratio is zero unless a zone hit with a nonzero overlap.
    always_comb begin
        o_data.hit           = r_st[NS-1].hit;
        o_data.zone_level    = r_st[NS-1].level;
        o_data.overlap_ratio = (r_st[NS-1].hit && r_st[NS-1].nz) ? r_st[NS-1].quo : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                if (w_en[s]) begin
                    r_vld[s] <= w_vsrc[s];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < NS; s++) begin
            if (w_en[s]) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    // A hit with nonzero overlap never leaves a remainder at or above the area.
    a_rem_below_area: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && r_st[NS-1].hit && r_st[NS-1].nz |-> r_st[NS-1].rem < r_st[NS-1].area)
        else $error("divider remainder not below area");

    // A miss carries zone level zero.
    a_miss_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NS-1] && !r_st[NS-1].hit |-> r_st[NS-1].level == '0)
        else $error("miss with nonzero zone level");

    // The ratio never exceeds one.
    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_data.overlap_ratio <= zop_pkg::COORD_ONE)
        else $error("overlap ratio above one");

endmodule

// ===== hw/rtl/zone_overlap_priority_hit.sv =====
// Top level: zone registers and the clip, hit test and divide pipeline.
// Each beat is one detection box; one result beat comes out per box, in order.
// The pipeline takes a box every cycle unless the output stalls, and has ten
// register stages (two for clipping and area multiplies, two for the threshold
// test and winner select, six for the ratio divider, which retires two quotient
// bits per stage). Bubbles are absorbed stage by stage, so new boxes are taken
// while a result waits. The user must write zone registers through the cfg port
// only while idle; the block itself does not enforce this.
module zone_overlap_priority_hit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  zop_pkg::t_box_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output zop_pkg::t_hit_out                 o_out_data,
    input  logic                              i_cfg_we,
    input  logic [zop_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [zop_pkg::ZONE_REG_W-1:0]    i_cfg_data
);

    zop_pkg::t_zone_reg r_zone [zop_pkg::NUM_ZONES];

    logic            w_g_valid, w_g_ready;
    zop_pkg::t_geom  w_g_data;
    logic            w_h_valid, w_h_ready;
    zop_pkg::t_div   w_h_data;

    // Zone registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int z = 0; z < zop_pkg::NUM_ZONES; z++) begin
                r_zone[z] <= '0;
            end
        end else begin
            for (int z = 0; z < zop_pkg::NUM_ZONES; z++) begin
                if (i_cfg_we && (i_cfg_idx == zop_pkg::CFG_IDX_W'(z))) begin
                    r_zone[z] <= i_cfg_data;
                end
            end
        end
    end

    zop_geom u_geom (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_zone  (r_zone),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_data  (i_in_data),
        .o_valid (w_g_valid),
        .i_ready (w_g_ready),
        .o_data  (w_g_data)
    );

    zop_hit u_hit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_g_valid),
        .o_ready (w_g_ready),
        .i_data  (w_g_data),
        .o_valid (w_h_valid),
        .i_ready (w_h_ready),
        .o_data  (w_h_data)
    );

    zop_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_h_valid),
        .o_ready (w_h_ready),
        .i_data  (w_h_data),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    // No result beat right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A miss reports a zero ratio.
    a_miss_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.hit |-> o_out_data.overlap_ratio == '0)
        else $error("miss with nonzero ratio");

    // The winning zone is active in the zone registers.
    a_win_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.hit |->
            r_zone[o_out_data.zone_level][zop_pkg::ACTIVE_BIT])
        else $error("hit reported on an inactive zone");

endmodule

// ===== tb/sv/zone_overlap_priority_hit_chk.sv =====
// Checker for the zone overlap priority hit block: predicts each result and compares.
module zone_overlap_priority_hit_chk (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  zop_pkg::t_box_in                i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  zop_pkg::t_hit_out               i_out_data,
    input  logic                            i_cfg_we,
    input  logic [zop_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [zop_pkg::ZONE_REG_W-1:0]  i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);

    zop_pkg::t_zone_reg zone_q[zop_pkg::NUM_ZONES];
    zop_pkg::t_hit_out  hits_due[$];

    // Holds a coordinate at one when it lies above one.
    function automatic longint sat_coord(logic [zop_pkg::COORD_W-1:0] v);
        return (v > zop_pkg::COORD_ONE) ? longint'(zop_pkg::COORD_ONE) : longint'(v);
    endfunction

    // Works out the winning zone and its overlap for one box.
    function automatic zop_pkg::t_hit_out zone_winner(zop_pkg::t_box_in b);
        zop_pkg::t_hit_out r;
        longint bx1, by1, bx2, by2, area, thr, ix1, iy1, ix2, iy2, inter, one;
        logic hit;
        logic ok;
        r = '0;
        one = longint'(zop_pkg::COORD_ONE);
        bx1 = sat_coord(b.box_left);
        by1 = sat_coord(b.box_top);
        bx2 = sat_coord(b.box_right);
        by2 = sat_coord(b.box_bottom);
        ok = (bx2 > bx1) && (by2 > by1);
        area = ok ? (bx2 - bx1) * (by2 - by1) : 0;
        for (int z = 0; z < zop_pkg::NUM_ZONES; z++) begin
            if (!zone_q[z][zop_pkg::ACTIVE_BIT]) continue;
            thr = longint'(zone_q[z][zop_pkg::SLOT_THR*zop_pkg::COORD_W +: zop_pkg::COORD_W]);
            ix1 = sat_coord(zone_q[z][zop_pkg::SLOT_X1*zop_pkg::COORD_W +: zop_pkg::COORD_W]);
            iy1 = sat_coord(zone_q[z][zop_pkg::SLOT_Y1*zop_pkg::COORD_W +: zop_pkg::COORD_W]);
            ix2 = sat_coord(zone_q[z][zop_pkg::SLOT_X2*zop_pkg::COORD_W +: zop_pkg::COORD_W]);
            iy2 = sat_coord(zone_q[z][zop_pkg::SLOT_Y2*zop_pkg::COORD_W +: zop_pkg::COORD_W]);
            if (bx1 > ix1) ix1 = bx1;
            if (by1 > iy1) iy1 = by1;
            if (bx2 < ix2) ix2 = bx2;
            if (by2 < iy2) iy2 = by2;
            inter = (ix2 > ix1 && iy2 > iy1 && ok) ? (ix2 - ix1) * (iy2 - iy1) : 0;
            if (inter > 0) hit = inter * one >= thr * area;
            else hit = (thr == 0);
            if (hit) begin
                r.hit = 1'b1;
                r.zone_level = zop_pkg::LEVEL_W'(z);
                r.overlap_ratio = (inter > 0) ? zop_pkg::COORD_W'((inter * one) / area)
                                              : '0;
                return r;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        o_errors++;
    endtask

    // Track zone registers, queue predictions and compare result beats.
    always @(posedge i_clk) begin
        zop_pkg::t_hit_out want;
        if (!i_rst_n) begin
            for (int z = 0; z < zop_pkg::NUM_ZONES; z++) zone_q[z] = '0;
            hits_due.delete();
            o_errors = 0;
        end else begin
            if (i_cfg_we) zone_q[i_cfg_idx] = i_cfg_data;
            if (i_in_valid && i_in_ready) hits_due.push_back(zone_winner(i_in_data));
            if (i_out_valid && i_out_ready) begin
                if (hits_due.size() == 0) begin
                    report_mismatch("unexpected beat", 1, 0);
                end else begin
                    want = hits_due.pop_front();
                    if (i_out_data.hit !== want.hit)
                        report_mismatch("hit", int'(i_out_data.hit), int'(want.hit));
                    if (i_out_data.zone_level !== want.zone_level)
                        report_mismatch("zone_level", int'(i_out_data.zone_level),
                                        int'(want.zone_level));
                    if (i_out_data.overlap_ratio !== want.overlap_ratio)
                        report_mismatch("overlap_ratio", int'(i_out_data.overlap_ratio),
                                        int'(want.overlap_ratio));
                end
            end
        end
        o_pending = hits_due.size();
    end

endmodule

// ===== tb/sv/zone_overlap_priority_hit_tb.sv =====
// Testbench top for the zone overlap priority hit block: stimulus, zone settings and verdict.
module zone_overlap_priority_hit_tb;

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    zop_pkg::t_box_in               in_data;
    logic                           out_valid;
    logic                           out_ready;
    zop_pkg::t_hit_out              out_data;
    logic                           cfg_we;
    logic [zop_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [zop_pkg::ZONE_REG_W-1:0] cfg_data;
    int                             errors;
    int                             pending;
    int                             send_idle_pct;
    int                             recv_idle_pct;
    logic                           hold_off;

    zone_overlap_priority_hit u_top (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_ready(out_ready), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data)
    );

    zone_overlap_priority_hit_chk u_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_ready(out_ready), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_idx(cfg_idx), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, or a long hold-off when requested.
    always @(posedge clk) begin
        if (!rst_n) out_ready <= 1'b0;
        else if (hold_off) out_ready <= 1'b0;
        else out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Random coordinate, biased toward the clamp edges now and then.
    function automatic logic [zop_pkg::COORD_W-1:0] pick_coord();
        case ($urandom_range(9))
            0: return zop_pkg::COORD_ONE;
            1: return '0;
            2: return zop_pkg::COORD_W'($urandom);
            default: return zop_pkg::COORD_W'($urandom_range(2048));
        endcase
    endfunction

    function automatic zop_pkg::t_zone_reg make_zone(logic act,
                                                     logic [zop_pkg::COORD_W-1:0] thr,
                                                     logic [zop_pkg::COORD_W-1:0] x1,
                                                     logic [zop_pkg::COORD_W-1:0] y1,
                                                     logic [zop_pkg::COORD_W-1:0] x2,
                                                     logic [zop_pkg::COORD_W-1:0] y2);
        return {act, thr, x1, y1, x2, y2};
    endfunction

    // One register write, after which the write enable is dropped before the task returns.
    task automatic write_zone(int idx, zop_pkg::t_zone_reg v);
        cfg_we   <= 1'b1;
        cfg_idx  <= zop_pkg::CFG_IDX_W'(idx);
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        @(posedge clk);
    endtask

    // Drives one box beat and waits for it to be taken.
    task automatic send_box(logic [zop_pkg::COORD_W-1:0] l, logic [zop_pkg::COORD_W-1:0] t,
                            logic [zop_pkg::COORD_W-1:0] r, logic [zop_pkg::COORD_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{l, t, r, b};
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Random box: mostly well ordered, some inverted or degenerate.
    task automatic send_random_box();
        logic [zop_pkg::COORD_W-1:0] a, b, c, d;
        a = pick_coord(); b = pick_coord(); c = pick_coord(); d = pick_coord();
        if ($urandom_range(9) < 7) begin
            if (a > c) begin a = a ^ c; c = a ^ c; a = a ^ c; end
            if (b > d) begin b = b ^ d; d = b ^ d; b = b ^ d; end
        end
        send_box(a, b, c, d);
    endtask

    task automatic random_zones();
        logic [zop_pkg::COORD_W-1:0] x1, y1, x2, y2, thr;
        for (int z = 0; z < zop_pkg::NUM_ZONES; z++) begin
            x1 = pick_coord(); y1 = pick_coord(); x2 = pick_coord(); y2 = pick_coord();
            if ($urandom_range(3) != 0) begin
                if (x1 > x2) begin x1 = x1 ^ x2; x2 = x1 ^ x2; x1 = x1 ^ x2; end
                if (y1 > y2) begin y1 = y1 ^ y2; y2 = y1 ^ y2; y1 = y1 ^ y2; end
            end
            case ($urandom_range(5))
                0: thr = '0;
                1: thr = zop_pkg::COORD_W'($urandom);
                default: thr = zop_pkg::COORD_W'($urandom_range(1024));
            endcase
            write_zone(z, make_zone($urandom_range(4) != 0, thr, x1, y1, x2, y2));
        end
    endtask

    // Stimulus: directed boxes, then random phases with changing zones.
    initial begin
        rst_n = 1'b0; in_valid = 1'b0; in_data = '0; cfg_we = 1'b0;
        cfg_idx = '0; cfg_data = '0; hold_off = 1'b0;
        send_idle_pct = 0; recv_idle_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // All zones inactive: every box misses.
        send_box(12'd0, 12'd0, 12'd2048, 12'd2048);
        send_box(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        drain();

        // Overlapping zones; zone 3 has threshold 0, zone 2 an unreachable threshold.
        write_zone(0, make_zone(1'b1, 12'd1024, 12'd0, 12'd0, 12'd1024, 12'd1024));
        write_zone(1, make_zone(1'b1, 12'd2048, 12'd512, 12'd512, 12'd1536, 12'd1536));
        write_zone(2, make_zone(1'b1, 12'hFFF, 12'd0, 12'd0, 12'hFFF, 12'hFFF));
        write_zone(3, make_zone(1'b1, 12'd0, 12'd2047, 12'd2047, 12'd2048, 12'd2048));
        send_box(12'd0, 12'd0, 12'd1024, 12'd1024);       // full overlap of zone 0
        send_box(12'd0, 12'd0, 12'd2048, 12'd2048);       // quarter overlaps, falls to zone 3
        send_box(12'd600, 12'd600, 12'd1400, 12'd1400);   // inside zone 1
        send_box(12'd1024, 12'd0, 12'd0, 12'd1024);       // inverted box
        send_box(12'd500, 12'd500, 12'd500, 12'd900);     // zero width box
        send_box(12'hFFF, 12'd0, 12'hFFF, 12'd2048);      // clamped to zero width
        send_box(12'd0, 12'd0, 12'hFFF, 12'hFFF);         // clamped corners
        send_box(12'd2047, 12'd2047, 12'd2048, 12'd2048); // smallest box
        send_box(12'd1500, 12'd0, 12'd2048, 12'd100);     // does not reach zone 0
        send_box(12'hAAA, 12'h555, 12'h555, 12'hAAA);
        drain();
        write_zone(3, make_zone(1'b0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0));
        write_zone(2, make_zone(1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0, 12'd0));
        send_box(12'd1600, 12'd1600, 12'd1700, 12'd1700); // misses everything
        send_box(12'd0, 12'd0, 12'd1, 12'd1);
        send_box(12'h555, 12'hAAA, 12'hFFF, 12'hFFF);
        drain();

        // Random phases: idling profiles, zones rewritten between them.
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = (ph < 3) ? 8 : (ph < 6) ? 45 : 0;
            recv_idle_pct = (ph < 3) ? 45 : (ph < 6) ? 8 : 0;
            if (ph == 8) begin
                write_zone(0, make_zone(1'b1, 12'd0, 12'd0, 12'd0, 12'd2048, 12'd2048));
                write_zone(1, make_zone(1'b1, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF));
                write_zone(2, {zop_pkg::ZONE_REG_W{1'b1}});
                write_zone(3, '0);
            end else begin
                random_zones();
            end
            if (ph == 4) begin
                // Long receiver hold-off while boxes keep coming.
                hold_off <= 1'b1;
                fork
                    begin repeat (60) @(posedge clk); hold_off <= 1'b0; end
                    repeat (40) send_random_box();
                join
            end
            repeat (75) send_random_box();
            drain();
        end

        if (errors == 0) $display("zone_overlap_priority_hit_tb passed");
        else $display("zone_overlap_priority_hit_tb failed");
        $finish;
    end

    initial begin
        #400000;
        $display("zone_overlap_priority_hit_tb failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/zop_pkg.sv
hw/rtl/zop_geom.sv
hw/rtl/zop_hit.sv
hw/rtl/zop_div.sv
hw/rtl/zone_overlap_priority_hit.sv
tb/sv/zone_overlap_priority_hit_chk.sv
tb/sv/zone_overlap_priority_hit_tb.sv
